### sv/cbpd_pkg.sv
// Shared constants, payload type and blend ROM contents for the cosine blend PD controller.
// No dependencies; used by cosine_blend_pd_current_control.
package cbpd_pkg;

	localparam int COS_TABLE_DEPTH = 1024;
	localparam int FRAC_BITS       = 16;
	localparam int S_BITS          = 30;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// quotient / ROM index width, holds COS_TABLE_DEPTH itself
	localparam int KW = $clog2(COS_TABLE_DEPTH + 1);
	// blend numerator 2*tt*DEPTH + dur
	localparam int NW = 32 + $clog2(2 * COS_TABLE_DEPTH + 1) + 1;
	// signed PD sum width
	localparam int PW = 66 - FRAC_BITS;
	localparam int CW = PW + 2;

	localparam int CFG_AW = 3;
	localparam logic [CFG_AW-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_DAMP_GAIN  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_FIRST_DUR  = 3'd2;
	localparam logic [CFG_AW-1:0] REG_SECOND_DUR = 3'd3;
	localparam logic [CFG_AW-1:0] REG_FIRST_DLY  = 3'd4;

	localparam logic [31:0] PROP_GAIN_RST  = 32'd6553600;
	localparam logic [31:0] DAMP_GAIN_RST  = 32'd65536;
	localparam logic [31:0] FIRST_DUR_RST  = 32'd10000;
	localparam logic [31:0] SECOND_DUR_RST = 32'd10000;
	localparam logic [31:0] FIRST_DLY_RST  = 32'd0;

	localparam logic [1:0] MODE_HOLD  = 2'd0;
	localparam logic [1:0] MODE_DELAY = 2'd1;
	localparam logic [1:0] MODE_BLEND = 2'd2;

	typedef struct packed {
		logic signed [31:0] start_pos;
		logic signed [31:0] target_pos;
		logic signed [31:0] actual_pos;
		logic signed [31:0] velocity;
		logic [30:0]        limit;
		logic               blend;
		logic               fin;
	} pl_t;

	typedef logic [S_BITS:0] rom_t [0:COS_TABLE_DEPTH];

	// shift-and-subtract quotient, used only while building the ROM
	function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
		longint unsigned q, r;
		q = 64'd0;
		r = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// (1-cos x)/2 in Q30 for x in Q30, truncated power series
	function automatic longint unsigned half_versine(longint unsigned x);
		longint unsigned x2, term, sum, dv;
		x2 = (x * x) >> 30;
		term = x2 >> 1;
		sum = term;
		for (int n = 2; n <= 12; n++) begin
			dv = longint'((2 * n - 1) * (2 * n));
			term = udiv((term * x2) >> 30, dv);
			if ((n % 2) == 0) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		sum = (sum + 64'd1) >> 1;
		if (sum > (64'd1 << S_BITS)) begin
			sum = 64'd1 << S_BITS;
		end
		return sum;
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		longint unsigned v, m;
		for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
			if (2 * k <= COS_TABLE_DEPTH) begin
				v = half_versine((PI_Q30 * longint'(k)) / COS_TABLE_DEPTH);
			end else begin
				m = longint'(COS_TABLE_DEPTH - k);
				v = (64'd1 << S_BITS) - half_versine((PI_Q30 * m) / COS_TABLE_DEPTH);
			end
			r[k] = v[S_BITS:0];
		end
		return r;
	endfunction

	localparam rom_t BLEND_ROM = build_rom();

endpackage

### sv/cosine_blend_pd_current_control.sv
// Cosine blend trajectory with PD current control, fully pipelined.
// Depends on cbpd_pkg (widths, register codes, blend ROM contents).
//
// channel  | ports                                             | handshake
// ---------+---------------------------------------------------+---------------------------
// sample   | mode .. current_limit                             | start & !busy
// result   | drive_current, desired_position, saturated        | done, one cycle, no stall
// config   | cfg_we, cfg_addr, cfg_wdata                       | cfg_we
//
// One sample enters every cycle; busy is always low.
// Registers in order (KW = 11 at 1024 entries): input register, one stage per quotient
// bit of the restoring divider that finds the ROM index, then ROM read, blend product,
// setpoint, error magnitudes, gain products, signed difference and clamp.
// Reset clears the valid bits and the registers to their defaults; data registers are not reset.
module cosine_blend_pd_current_control (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [31:0]                  elapsed_ticks,
	input  logic signed [31:0]           start_position,
	input  logic signed [31:0]           target_position,
	input  logic signed [31:0]           actual_position,
	input  logic signed [31:0]           actual_velocity,
	input  logic [30:0]                  current_limit,
	input  logic                         cfg_we,
	input  logic [cbpd_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [31:0]                  cfg_wdata,
	output logic                         done,
	output logic signed [31:0]           drive_current,
	output logic signed [31:0]           desired_position,
	output logic                         saturated
);

	localparam int KW = cbpd_pkg::KW;
	localparam int NW = cbpd_pkg::NW;
	localparam int CW = cbpd_pkg::CW;
	localparam int FB = cbpd_pkg::FRAC_BITS;
	localparam int SB = cbpd_pkg::S_BITS;

	logic [31:0] prop_gain_q, damp_gain_q, first_dur_q, second_dur_q, first_dly_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= cbpd_pkg::PROP_GAIN_RST;
			damp_gain_q  <= cbpd_pkg::DAMP_GAIN_RST;
			first_dur_q  <= cbpd_pkg::FIRST_DUR_RST;
			second_dur_q <= cbpd_pkg::SECOND_DUR_RST;
			first_dly_q  <= cbpd_pkg::FIRST_DLY_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				cbpd_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_wdata;
				cbpd_pkg::REG_DAMP_GAIN:  damp_gain_q  <= cfg_wdata;
				cbpd_pkg::REG_FIRST_DUR:  first_dur_q  <= cfg_wdata;
				cbpd_pkg::REG_SECOND_DUR: second_dur_q <= cfg_wdata;
				cbpd_pkg::REG_FIRST_DLY:  first_dly_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// ---- stage 1: pick blend, form divider operands
	logic        acc;
	logic        blend_c, fin_c;
	logic [31:0] tt_c, dur_c;
	assign acc = start && !busy;

	always_comb begin
		blend_c = 1'b0;
		tt_c = elapsed_ticks;
		dur_c = second_dur_q;
		case (mode)
			cbpd_pkg::MODE_DELAY: begin
				blend_c = (elapsed_ticks >= first_dly_q);
				tt_c = elapsed_ticks - first_dly_q;
				dur_c = first_dur_q;
			end
			cbpd_pkg::MODE_BLEND: blend_c = 1'b1;
			default: blend_c = 1'b0;
		endcase
		fin_c = blend_c && (tt_c >= dur_c);
	end

	logic              vld_s1;
	cbpd_pkg::pl_t     pl_s1;
	logic [NW-1:0]     num_s1;
	logic [32:0]       den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		pl_s1.start_pos  <= start_position;
		pl_s1.target_pos <= target_position;
		pl_s1.actual_pos <= actual_position;
		pl_s1.velocity   <= actual_velocity;
		pl_s1.limit      <= current_limit;
		pl_s1.blend      <= blend_c;
		pl_s1.fin        <= fin_c;
		num_s1 <= NW'(tt_c) * NW'(2 * cbpd_pkg::COS_TABLE_DEPTH) + NW'(dur_c);
		den_s1 <= {dur_c, 1'b0};
	end

	// ---- restoring divider, one quotient bit per stage
	logic          dv_vld_s [KW];
	cbpd_pkg::pl_t dv_pl_s  [KW];
	logic [NW-1:0] dv_rem_s [KW];
	logic [32:0]   dv_den_s [KW];
	logic [KW-1:0] dv_q_s   [KW];

	for (genvar j = 0; j < KW; j++) begin : g_div
		logic          vin;
		cbpd_pkg::pl_t pin;
		logic [NW-1:0] rin, sh;
		logic [32:0]   din;
		logic [KW-1:0] qin;
		logic          take;

		if (j == 0) begin : g_first
			assign vin = vld_s1;
			assign pin = pl_s1;
			assign rin = num_s1;
			assign din = den_s1;
			assign qin = '0;
		end else begin : g_next
			assign vin = dv_vld_s[j-1];
			assign pin = dv_pl_s[j-1];
			assign rin = dv_rem_s[j-1];
			assign din = dv_den_s[j-1];
			assign qin = dv_q_s[j-1];
		end

		assign sh   = NW'(din) << (KW - 1 - j);
		assign take = (rin >= sh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[j] <= 1'b0;
			else dv_vld_s[j] <= vin;
		end

		always_ff @(posedge clk) begin
			dv_pl_s[j]  <= pin;
			dv_den_s[j] <= din;
			dv_rem_s[j] <= take ? rin - sh : rin;
			dv_q_s[j]   <= qin | (take ? (KW'(1) << (KW - 1 - j)) : '0);
		end
	end

	// ---- stage 3: ROM read and distance magnitude
	logic                vld_s3;
	cbpd_pkg::pl_t       pl_s3;
	logic [SB:0]         rom_s3;
	logic [32:0]         dmag_s3;
	logic                dneg_s3;
	logic [KW-1:0]       k_c;
	logic signed [32:0]  dist_c;

	assign k_c = (dv_q_s[KW-1] > KW'(cbpd_pkg::COS_TABLE_DEPTH)) ?
		KW'(cbpd_pkg::COS_TABLE_DEPTH) : dv_q_s[KW-1];
	assign dist_c = 33'(dv_pl_s[KW-1].target_pos) - 33'(dv_pl_s[KW-1].start_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= dv_vld_s[KW-1];
	end

	always_ff @(posedge clk) begin
		pl_s3   <= dv_pl_s[KW-1];
		rom_s3  <= cbpd_pkg::BLEND_ROM[k_c];
		dneg_s3 <= dist_c[32];
		dmag_s3 <= dist_c[32] ? 33'(-dist_c) : 33'(dist_c);
	end

	// ---- stage 4: blend product
	logic            vld_s4;
	cbpd_pkg::pl_t   pl_s4;
	logic [63:0]     prod_s4;
	logic            dneg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		pl_s4   <= pl_s3;
		dneg_s4 <= dneg_s3;
		prod_s4 <= 64'(dmag_s3) * 64'(rom_s3);
	end

	// ---- stage 5: setpoint
	logic               vld_s5;
	cbpd_pkg::pl_t      pl_s5;
	logic signed [31:0] des_s5;
	logic [63:0]        rnd_c;
	logic signed [33:0] bl_c;
	logic signed [31:0] des_c;

	assign rnd_c = (prod_s4 + (64'd1 << (SB - 1))) >> SB;
	always_comb begin
		bl_c = dneg_s4 ? 34'(pl_s4.start_pos) - 34'(rnd_c[32:0])
		               : 34'(pl_s4.start_pos) + 34'(rnd_c[32:0]);
		if (pl_s4.fin) des_c = pl_s4.target_pos;
		else if (pl_s4.blend) des_c = bl_c[31:0];
		else des_c = pl_s4.start_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		pl_s5  <= pl_s4;
		des_s5 <= des_c;
	end

	// ---- stage 6: error and velocity magnitudes
	logic               vld_s6;
	logic signed [31:0] des_s6;
	logic [30:0]        lim_s6;
	logic [32:0]        emag_s6;
	logic [31:0]        vmag_s6;
	logic               eneg_s6, vneg_s6;
	logic signed [32:0] err_c;

	assign err_c = 33'(des_s5) - 33'(pl_s5.actual_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		des_s6  <= des_s5;
		lim_s6  <= pl_s5.limit;
		eneg_s6 <= err_c[32];
		emag_s6 <= err_c[32] ? 33'(-err_c) : 33'(err_c);
		vneg_s6 <= pl_s5.velocity[31];
		vmag_s6 <= pl_s5.velocity[31] ? 32'(-pl_s5.velocity) : 32'(pl_s5.velocity);
	end

	// ---- stage 7: gain products
	logic               vld_s7;
	logic signed [31:0] des_s7;
	logic [30:0]        lim_s7;
	logic [64:0]        pp_s7;
	logic [63:0]        pv_s7;
	logic               eneg_s7, vneg_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		des_s7  <= des_s6;
		lim_s7  <= lim_s6;
		eneg_s7 <= eneg_s6;
		vneg_s7 <= vneg_s6;
		pp_s7   <= 65'(prop_gain_q) * 65'(emag_s6);
		pv_s7   <= 64'(damp_gain_q) * 64'(vmag_s6);
	end

	// ---- stage 8: signed difference
	logic               vld_s8;
	logic signed [31:0] des_s8;
	logic [30:0]        lim_s8;
	logic signed [CW-1:0] cur_s8;
	logic signed [CW-1:0] sp_c, sv_c;

	always_comb begin
		sp_c = CW'(pp_s7[64:FB]);
		sv_c = CW'(pv_s7[63:FB]);
		if (eneg_s7) sp_c = -sp_c;
		if (vneg_s7) sv_c = -sv_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		des_s8 <= des_s7;
		lim_s8 <= lim_s7;
		cur_s8 <= sp_c - sv_c;
	end

	// ---- stage 9: clamp and output
	logic signed [CW-1:0] lim_c;
	logic                 done_q, sat_q;
	logic signed [31:0]   drv_q, des_q;
	logic [30:0]          lim_q;

	assign lim_c = CW'(lim_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= vld_s8;
	end

	always_ff @(posedge clk) begin
		des_q <= des_s8;
		lim_q <= lim_s8;
		if (cur_s8 > lim_c) begin
			drv_q <= 32'(lim_c);
			sat_q <= 1'b1;
		end else if (cur_s8 < -lim_c) begin
			drv_q <= 32'(-lim_c);
			sat_q <= 1'b1;
		end else begin
			drv_q <= cur_s8[31:0];
			sat_q <= 1'b0;
		end
	end

	assign done             = done_q;
	assign drive_current    = drv_q;
	assign desired_position = des_q;
	assign saturated        = sat_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s1, KW + 7))
		else $error("result without matching transaction");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |-> (drive_current == 32'(lim_q)) ||
			(drive_current == -32'(lim_q)))
		else $error("saturated result not at the limit");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !saturated |->
			($signed({drive_current[31], drive_current}) <= $signed({2'b00, lim_q})) &&
			($signed({drive_current[31], drive_current}) >= -$signed({2'b00, lim_q})))
		else $error("unclamped result outside the limit");

	a_between: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> ((des_s5 >= pl_s5.start_pos) && (des_s5 <= pl_s5.target_pos)) ||
			((des_s5 <= pl_s5.start_pos) && (des_s5 >= pl_s5.target_pos)))
		else $error("setpoint outside start and target");

endmodule
